### hdl/lslf_pkg.sv
`timescale 1ns / 1ps
package lslf_pkg;
  localparam int MaxPoints = 255;
  localparam int FracBits = 16;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_DEGEN = 2'd1,
    ST_OVER = 2'd2
  } fit_status_t;

  // One finished set handed from the accumulator to the solver.
  typedef struct packed {
    logic signed [39:0] sxy;
    logic signed [24:0] sx;
    logic signed [24:0] sy;
    logic signed [39:0] sxx;
    logic [7:0] cnt;
    logic ovf;
  } lslf_sums_t;
endpackage

### hdl/lslf_in_if.sv
`timescale 1ns / 1ps
interface lslf_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;
  logic last_point;
  modport source(output valid, x_coord, y_coord, last_point, input ready);
  modport sink(input valid, x_coord, y_coord, last_point, output ready);
endinterface

### hdl/lslf_out_if.sv
`timescale 1ns / 1ps
interface lslf_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] slope;
  logic signed [31:0] intercept;
  logic [1:0] fit_status;
  logic [7:0] points_used;
  modport source(output valid, slope, intercept, fit_status, points_used, input ready);
  modport sink(input valid, slope, intercept, fit_status, points_used, output ready);
endinterface

### hdl/lslf_divider.sv
`timescale 1ns / 1ps
module lslf_divider (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  dividend,
  input  logic [63:0]  divisor,
  output logic         done,
  output logic [63:0]  quotient,
  output logic [63:0]  remainder
);
  // Unsigned restoring divider, one quotient bit per cycle.
  logic [63:0] q_r, q_nxt, r_r, r_nxt, d_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {r_r, q_r[63]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend;
      r_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        r_nxt = trial[63:0];
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        r_nxt = {r_r[62:0], q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) d_r <= divisor;
  end

  assign done = done_r;
  assign quotient = q_r;
  assign remainder = r_r;
endmodule

### hdl/lslf_front.sv
`timescale 1ns / 1ps
module lslf_front (
  input  logic clk,
  input  logic rst_n,
  lslf_in_if.sink in_ch,
  output logic push,
  output lslf_pkg::lslf_sums_t push_data,
  input  logic full
);
  import lslf_pkg::*;
  logic signed [39:0] sxy_r, sxx_r;
  logic signed [24:0] sx_r, sy_r;
  logic [7:0] cnt_r;
  logic ovf_r;
  logic signed [31:0] pxy_r, pxx_r;
  logic signed [15:0] x_r, y_r;
  logic v1_r, last1_r, acc1_r;
  logic take;
  logic signed [39:0] sxy_nxt, sxx_nxt;
  logic signed [24:0] sx_nxt, sy_nxt;
  logic [7:0] cnt_nxt;
  logic ovf_nxt;
  logic acc0;

  // A stage squares the point, the next adds it; a marked word waits for queue room.
  assign in_ch.ready = !(v1_r && last1_r && full);
  assign take = in_ch.valid && in_ch.ready;
  assign acc0 = (cnt_r < 8'(MaxPoints)) &&
                !(v1_r && !last1_r && acc1_r && (cnt_r + 8'd1 >= 8'(MaxPoints)));

  always_comb begin
    sxy_nxt = sxy_r; sxx_nxt = sxx_r; sx_nxt = sx_r; sy_nxt = sy_r;
    cnt_nxt = cnt_r; ovf_nxt = ovf_r;
    if (v1_r && in_ch.ready) begin
      if (acc1_r) begin
        sxy_nxt = sxy_r + 40'(pxy_r);
        sxx_nxt = sxx_r + 40'(pxx_r);
        sx_nxt = sx_r + 25'(x_r);
        sy_nxt = sy_r + 25'(y_r);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (cnt_r != 8'd255) cnt_nxt = cnt_r + 8'd1;
    end
    push_data.sxy = sxy_nxt; push_data.sxx = sxx_nxt;
    push_data.sx = sx_nxt; push_data.sy = sy_nxt;
    push_data.cnt = cnt_nxt; push_data.ovf = ovf_nxt;
  end
  assign push = v1_r && last1_r && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      sxy_r <= '0; sxx_r <= '0; sx_r <= '0; sy_r <= '0; cnt_r <= '0; ovf_r <= 1'b0;
    end else if (in_ch.ready) begin
      v1_r <= take;
      if (push) begin
        sxy_r <= '0; sxx_r <= '0; sx_r <= '0; sy_r <= '0; cnt_r <= '0; ovf_r <= 1'b0;
      end else begin
        sxy_r <= sxy_nxt; sxx_r <= sxx_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
        cnt_r <= cnt_nxt; ovf_r <= ovf_nxt;
      end
    end
    if (in_ch.ready) begin
      x_r <= in_ch.x_coord;
      y_r <= in_ch.y_coord;
      pxy_r <= in_ch.x_coord * in_ch.y_coord;
      pxx_r <= in_ch.x_coord * in_ch.x_coord;
      last1_r <= in_ch.last_point;
      acc1_r <= (v1_r && last1_r) ? 1'b1 : acc0;
    end
  end
endmodule

### hdl/lslf_queue.sv
`timescale 1ns / 1ps
module lslf_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  lslf_pkg::lslf_sums_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output lslf_pkg::lslf_sums_t pop_data
);
  import lslf_pkg::*;
  lslf_sums_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule

### hdl/lslf_back.sv
`timescale 1ns / 1ps
module lslf_back (
  input  logic clk,
  input  logic rst_n,
  input  logic not_empty,
  input  lslf_pkg::lslf_sums_t sums,
  output logic pop,
  lslf_out_if.source out_ch
);
  import lslf_pkg::*;
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001, S_PROD = 11'b00000000010, S_DIV1 = 11'b00000000100,
    S_DIV2 = 11'b00000001000, S_SLOPE = 11'b00000010000, S_DIV3 = 11'b00000100000,
    S_MULB = 11'b00001000000, S_ICPT = 11'b00010000000, S_DIV4 = 11'b00100000000,
    S_FIN = 11'b01000000000, S_OUT = 11'b10000000000
  } state_t;
  state_t st_r, st_nxt;
  lslf_sums_t s_r;
  logic signed [49:0] sxsy_r, sxsx_r;
  logic signed [63:0] num_r, den_r;
  logic signed [31:0] slope_r, icpt_r;
  logic signed [63:0] bnum_r;
  logic [1:0] stat_r;
  logic neg_r;
  logic [63:0] q_hold_r;
  logic dstart;
  logic [63:0] dnd, dsr, dq, drm;
  logic ddone;
  logic [63:0] mag;
  logic [63:0] qs;
  logic [63:0] abs_num, abs_den;

  lslf_divider u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .dividend(dnd),
    .divisor(dsr), .done(ddone), .quotient(dq), .remainder(drm));

  function automatic logic [63:0] absv(input logic signed [63:0] v);
    absv = v[63] ? 64'(-v) : 64'(v);
  endfunction
  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat = 32'sh80000000;
    else sat = v[31:0];
  endfunction

  assign abs_num = absv(num_r);
  assign abs_den = absv(den_r);
  assign qs = neg_r ? 64'(-dq) : dq;

  always_comb begin
    st_nxt = st_r;
    dstart = 1'b0;
    dnd = absv(64'(sxsy_r));
    dsr = {56'd0, s_r.cnt};
    pop = 1'b0;
    mag = '0;
    unique case (st_r)
      S_IDLE: if (not_empty) begin pop = 1'b1; st_nxt = S_PROD; end
      S_PROD: begin
        dstart = !s_r.ovf;
        st_nxt = s_r.ovf ? S_OUT : S_DIV1;
      end
      S_DIV1: if (ddone) begin
        dstart = 1'b1; dnd = absv(64'(sxsx_r)); st_nxt = S_DIV2;
      end
      S_DIV2: if (ddone) st_nxt = S_SLOPE;
      S_SLOPE: begin
        if (den_r == 0) st_nxt = S_OUT;
        else begin
          dstart = 1'b1; dnd = abs_num; dsr = abs_den; st_nxt = S_DIV3;
        end
      end
      S_DIV3: if (ddone) begin
        dstart = 1'b1; dnd = drm << FracBits; dsr = abs_den; st_nxt = S_MULB;
      end
      S_MULB: if (ddone) begin
        if (q_hold_r > (64'd1 << (32 - FracBits))) mag = 64'd1 << 32;
        else begin
          mag = (q_hold_r << FracBits) + dq;
          if (mag > (64'd1 << 32)) mag = 64'd1 << 32;
        end
        st_nxt = S_ICPT;
      end
      S_ICPT: st_nxt = S_DIV4;
      S_DIV4: begin
        dstart = 1'b1; dnd = absv(bnum_r); st_nxt = S_FIN;
      end
      S_FIN: if (ddone) st_nxt = S_OUT;
      S_OUT: if (out_ch.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    unique case (st_r)
      S_IDLE: if (pop) begin
        s_r <= sums;
        sxsy_r <= sums.sx * sums.sy;
        sxsx_r <= sums.sx * sums.sx;
        slope_r <= '0; icpt_r <= '0;
        stat_r <= sums.ovf ? ST_OVER : ST_OK;
      end
      S_PROD: begin
        neg_r <= 1'b0;
      end
      S_DIV1: if (ddone) begin
        num_r <= 64'(s_r.sxy) - (sxsy_r[49] ? 64'(-dq) : dq);
      end
      S_DIV2: if (ddone) den_r <= 64'(s_r.sxx) - 64'(dq);
      S_SLOPE: begin
        if (den_r == 0) stat_r <= ST_DEGEN;
        neg_r <= num_r[63] ^ den_r[63];
      end
      S_DIV3: if (ddone) q_hold_r <= dq;
      S_MULB: if (ddone) begin
        if (neg_r) slope_r <= (mag > (64'd1 << 31)) ? 32'sh80000000 : 32'(-mag);
        else slope_r <= (mag > 64'd2147483647) ? 32'sh7fffffff : mag[31:0];
      end
      S_DIV4: neg_r <= bnum_r[63];
      S_FIN: if (ddone) icpt_r <= sat(qs);
      default: ;
    endcase
  end

  // Intercept numerator: Sy*2^F minus slope*Sx, formed after the slope is stored.
  always_ff @(posedge clk) begin
    if (st_r == S_FIN || st_r == S_OUT || st_r == S_IDLE) bnum_r <= '0;
    if (st_r == S_ICPT)
      bnum_r <= (64'(s_r.sy) <<< FracBits) - 64'(slope_r) * 64'(s_r.sx);
  end

  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.slope = slope_r;
  assign out_ch.intercept = icpt_r;
  assign out_ch.fit_status = stat_r;
  assign out_ch.points_used = s_r.cnt;
endmodule

### hdl/least_squares_line_fit.sv
`timescale 1ns / 1ps
// Points are taken at one word per cycle unless a set's last point waits for queue room.
// Each accepted point is registered with its products, then added to the sums. Results
// come from the shared 64-step restoring divider, up to five divisions per set.
// A new set may stream in while the previous one is solved; two sets can queue.
// Synchronous active-low reset clears the sums, queue and solver state.
module least_squares_line_fit (
  input logic clk,
  input logic rst_n,
  lslf_in_if.sink in_ch,
  lslf_out_if.source out_ch
);
  import lslf_pkg::*;
  logic push, full, pop, not_empty;
  lslf_sums_t push_data, pop_data;

  // Front end: squares and accumulates each point up to the limit, hands closed sets to the queue.
  lslf_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .push(push),
    .push_data(push_data), .full(full));

  // Short queue so that accumulation and solving stall independently.
  lslf_queue u_queue (.clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .full(full), .pop(pop), .not_empty(not_empty), .pop_data(pop_data));

  // Back end: the sequenced solver with its shared divider.
  lslf_back u_back (.clk(clk), .rst_n(rst_n), .not_empty(not_empty), .sums(pop_data),
    .pop(pop), .out_ch(out_ch));
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the streaming line fit. Points are fed as words on the
// input channel; every finished set yields one result word that is compared with
// a behavioural prediction kept in this module.
module tb_top;
  import lslf_pkg::*;

  localparam int OrdinaryPoints = 830;
  localparam int StallLimit = 6000;
  localparam int DrainCycles = 400;

  // One result word as the block should present it.
  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    fit_status_t status;
    logic [7:0] points;
  } line_result_t;

  // One row of the directed part. Rows marked typed carry their result by hand.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit last;
    bit typed;
    fit_status_t status;
    logic [7:0] points;
  } point_row_t;

  logic clk;
  logic rst_n;

  lslf_in_if in_ch ();
  lslf_out_if out_ch ();

  least_squares_line_fit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shadow of the accumulator state that the block keeps.
  longint acc_sxy;
  longint acc_sx;
  longint acc_sy;
  longint acc_sxx;
  int unsigned acc_count;
  bit acc_overflowed;

  line_result_t pending_fits[$];
  int errors;
  int points_sent;
  int sets_sent;
  int degenerate_sets;
  int overflowed_sets;
  int idle_cycles;
  bit quiet;

  // Folds one point into the shadow sums. When the point closes a set the
  // fitted line is returned and the sums are cleared, as the block does.
  function automatic bit fit_point(input logic signed [15:0] x, input logic signed [15:0] y,
                                   input bit last, output line_result_t fit);
    longint xl;
    longint yl;
    longint n;
    longint num;
    longint den;
    longint slp;
    longint icp;
    logic [63:0] an;
    logic [63:0] ad;
    logic [63:0] q;
    logic [63:0] rm;
    logic [63:0] mag;
    logic [63:0] cap;
    bit neg;
    xl = x;
    yl = y;
    fit = '0;
    if (acc_count < MaxPoints) begin
      acc_sxy += xl * yl;
      acc_sx += xl;
      acc_sy += yl;
      acc_sxx += xl * xl;
    end else begin
      acc_overflowed = 1'b1;
    end
    if (acc_count < 255) acc_count++;
    if (!last) return 1'b0;

    n = acc_count;
    slp = 0;
    icp = 0;
    if (acc_overflowed) begin
      fit.status = ST_OVER;
    end else begin
      num = acc_sxy - (acc_sx * acc_sy) / n;
      den = acc_sxx - (acc_sx * acc_sx) / n;
      if (den == 0) begin
        fit.status = ST_DEGEN;
      end else begin
        fit.status = ST_OK;
        // Exact fixed-point quotient, truncated toward zero, clamped to 32 bits.
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = an / ad;
        rm = an % ad;
        cap = 64'd1 << 32;
        if (q > (cap >> FracBits)) begin
          mag = cap;
        end else begin
          mag = (q << FracBits) + ((rm << FracBits) / ad);
          if (mag > cap) mag = cap;
        end
        if (neg) begin
          slp = (mag > (64'd1 << 31)) ? -64'sd2147483648 : -longint'(mag);
        end else begin
          slp = (mag > 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
        end
        // The intercept is built from the already clamped slope.
        icp = (acc_sy * (longint'(1) << FracBits) - slp * acc_sx) / n;
        if (icp > 64'sd2147483647) icp = 64'sd2147483647;
        if (icp < -64'sd2147483648) icp = -64'sd2147483648;
      end
    end
    fit.slope = slp[31:0];
    fit.intercept = icp[31:0];
    fit.points = acc_count[7:0];
    acc_sxy = 0;
    acc_sx = 0;
    acc_sy = 0;
    acc_sxx = 0;
    acc_count = 0;
    acc_overflowed = 1'b0;
    return 1'b1;
  endfunction

  // Presents one point and holds it until the block takes it. A random gap may
  // come first; valid is only lowered in a step where it is not raised again.
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input bit last, input bit typed, input line_result_t typed_fit);
    line_result_t fit;
    while (!quiet && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.x_coord <= x;
    in_ch.y_coord <= y;
    in_ch.last_point <= last;
    do @(posedge clk); while (!in_ch.ready);
    // The word was taken at this edge, so its prediction is queued now.
    if (fit_point(x, y, last, fit)) begin
      pending_fits.push_back(typed ? typed_fit : fit);
      sets_sent++;
      if (fit.status == ST_DEGEN) degenerate_sets++;
      if (fit.status == ST_OVER) overflowed_sets++;
    end
    points_sent++;
  endtask

  // Random coordinate: full range, a narrow band, or one of the extremes.
  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(9))
      0: pick_coord = 16'sh8000;
      1: pick_coord = 16'sh7fff;
      2, 3, 4: pick_coord = 16'($signed($urandom_range(0, 400)) - 200);
      default: pick_coord = 16'($urandom);
    endcase
  endfunction

  // A whole set of random points; the last one carries the marker.
  task automatic send_set(input int len);
    line_result_t none;
    logic signed [15:0] x0;
    bit same_x;
    none = '0;
    x0 = pick_coord();
    // Now and then every x of a set is equal, which leaves no denominator.
    same_x = ($urandom_range(15) == 0);
    for (int i = 0; i < len; i++) begin
      send_point(same_x ? x0 : pick_coord(), pick_coord(),
                 i == len - 1, 1'b0, none);
    end
  endtask

  // Result side: random back-pressure, field checks and the stall watchdog.
  always @(posedge clk) begin
    line_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(99) >= 7);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
          $display("%0t: no word moved for %0d cycles", $time, StallLimit);
          $display("tb: failure");
          $finish;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_fits.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word slope %0d intercept %0d", $time,
                   out_ch.slope, out_ch.intercept);
        end else begin
          want = pending_fits.pop_front();
          if (out_ch.slope !== want.slope) begin
            errors++;
            $display("%0t: slope expected %0d actual %0d", $time, want.slope, out_ch.slope);
          end
          if (out_ch.intercept !== want.intercept) begin
            errors++;
            $display("%0t: intercept expected %0d actual %0d", $time, want.intercept,
                     out_ch.intercept);
          end
          if (out_ch.fit_status !== want.status) begin
            errors++;
            $display("%0t: fit_status expected %0d actual %0d", $time, want.status,
                     out_ch.fit_status);
          end
          if (out_ch.points_used !== want.points) begin
            errors++;
            $display("%0t: points_used expected %0d actual %0d", $time, want.points,
                     out_ch.points_used);
          end
        end
      end
    end
  end

  point_row_t directed[19];

  initial begin
    line_result_t typed_fit;
    int ordinary;
    int len;
    // Directed rows: lone point, equal x, a clean slope of two, clamped slopes
    // both ways, the coordinate extremes and a small mixed set.
    directed = '{
      '{16'sd100, 16'sd200, 1'b1, 1'b1, ST_DEGEN, 8'd1},
      '{16'sd5, 16'sd1, 1'b0, 1'b0, ST_OK, 8'd0},
      '{16'sd5, 16'sd9, 1'b1, 1'b1, ST_DEGEN, 8'd2},
      '{16'sd0, 16'sd0, 1'b0, 1'b0, ST_OK, 8'd0},
      '{16'sd1, 16'sd2, 1'b0, 1'b0, ST_OK, 8'd0},
      '{16'sd2, 16'sd4, 1'b1, 1'b0, ST_OK, 8'd0},
      '{16'sd0, 16'sh8000, 1'b0, 1'b0, ST_OK, 8'd0},
      '{16'sd1, 16'sh7fff, 1'b1, 1'b0, ST_OK, 8'd0},
      '{16'sd0, 16'sh7fff, 1'b0, 1'b0, ST_OK, 8'd0},
      '{16'sd1, 16'sh8000, 1'b1, 1'b0, ST_OK, 8'd0},
      '{16'sh8000, 16'sh8000, 1'b0, 1'b0, ST_OK, 8'd0},
      '{16'sh7fff, 16'sh7fff, 1'b1, 1'b0, ST_OK, 8'd0},
      '{16'sh8000, 16'sh7fff, 1'b0, 1'b0, ST_OK, 8'd0},
      '{16'sh7fff, 16'sh8000, 1'b1, 1'b0, ST_OK, 8'd0},
      '{16'sd3, -16'sd7, 1'b0, 1'b0, ST_OK, 8'd0},
      '{-16'sd4, 16'sd11, 1'b0, 1'b0, ST_OK, 8'd0},
      '{16'sd10, 16'sd2, 1'b0, 1'b0, ST_OK, 8'd0},
      '{-16'sd1, -16'sd1, 1'b1, 1'b0, ST_OK, 8'd0},
      '{16'sh8000, 16'sd5, 1'b1, 1'b1, ST_DEGEN, 8'd2}
    };
    // The last row would close a set of its own; it is given a partner point of the
    // same x first, and the pair is typed as degenerate with two points.
    acc_sxy = 0;
    acc_sx = 0;
    acc_sy = 0;
    acc_sxx = 0;
    acc_count = 0;
    acc_overflowed = 1'b0;
    errors = 0;
    points_sent = 0;
    sets_sent = 0;
    degenerate_sets = 0;
    overflowed_sets = 0;
    quiet = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.x_coord <= '0;
    in_ch.y_coord <= '0;
    in_ch.last_point <= 1'b0;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    typed_fit = '0;
    for (int i = 0; i < $size(directed); i++) begin
      if (i == $size(directed) - 1) send_point(16'sh8000, -16'sd3, 1'b0, 1'b0, typed_fit);
      typed_fit.slope = '0;
      typed_fit.intercept = '0;
      typed_fit.status = directed[i].status;
      typed_fit.points = directed[i].points;
      send_point(directed[i].x, directed[i].y, directed[i].last, directed[i].typed, typed_fit);
    end

    // Random sets, mostly short. Long sets reach the point limit exactly, or go
    // past it so that the count saturates and the overflow status is raised.
    ordinary = 0;
    while (ordinary < OrdinaryPoints) begin
      quiet = (ordinary > 300 && ordinary < 450);
      if (sets_sent == 20) begin
        send_set(MaxPoints);
        ordinary += MaxPoints;
      end
      if (sets_sent == 40) begin
        len = MaxPoints + 1 + int'($urandom_range(0, 30));
        send_set(len);
        ordinary += len;
      end
      len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 8);
      send_set(len);
      ordinary += len;
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_fits.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Fitted %0d sets from %0d points: %0d degenerate, %0d past the point limit.",
             sets_sent, points_sent, degenerate_sets, overflowed_sets);
    if (errors == 0 && pending_fits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", errors, pending_fits.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
